/* sv/cdh_pkg.sv */
`timescale 1ns / 1ps
// Shared types, constants and decode tables for the hash64 digest decoder.
package cdh_pkg;

  localparam logic [1:0] MODE_MD5    = 2'd0;
  localparam logic [1:0] MODE_SHA256 = 2'd1;
  localparam logic [1:0] MODE_SHA512 = 2'd2;

  localparam logic [6:0] LEN_MD5    = 7'd22;
  localparam logic [6:0] LEN_SHA256 = 7'd43;
  localparam logic [6:0] LEN_SHA512 = 7'd86;
  localparam logic [6:0] COUNT_MAX  = 7'd127;

  localparam logic [4:0] GROUPS_MD5    = 5'd5;
  localparam logic [4:0] GROUPS_SHA256 = 5'd10;
  localparam logic [4:0] GROUPS_SHA512 = 5'd21;

  localparam logic [5:0] TAIL_POS_MD5     = 6'd11;
  localparam logic [5:0] TAIL_POS_SHA256A = 6'd30;
  localparam logic [5:0] TAIL_POS_SHA256B = 6'd31;
  localparam logic [5:0] TAIL_POS_SHA512  = 6'd63;

  localparam logic [7:0] CHR_DOT   = 8'h2e;
  localparam logic [7:0] CHR_SLASH = 8'h2f;
  localparam logic [7:0] OFS_DIGIT = 8'h2e;
  localparam logic [7:0] OFS_UPPER = 8'h35;
  localparam logic [7:0] OFS_LOWER = 8'h3b;

  localparam int JOB_Q_DEPTH = 4;
  localparam int JOB_Q_PTR_W = $clog2(JOB_Q_DEPTH);
  localparam int JOB_Q_CNT_W = $clog2(JOB_Q_DEPTH + 1);

  localparam logic [5:0] PERM_MD5 [15] = '{
    6'd12, 6'd6, 6'd0, 6'd13, 6'd7, 6'd1, 6'd14, 6'd8, 6'd2,
    6'd15, 6'd9, 6'd3, 6'd5, 6'd10, 6'd4
  };

  localparam logic [5:0] PERM_SHA256 [30] = '{
    6'd20, 6'd10, 6'd0, 6'd11, 6'd1, 6'd21, 6'd2, 6'd22, 6'd12,
    6'd23, 6'd13, 6'd3, 6'd14, 6'd4, 6'd24, 6'd5, 6'd25, 6'd15,
    6'd26, 6'd16, 6'd6, 6'd17, 6'd7, 6'd27, 6'd8, 6'd28, 6'd18,
    6'd29, 6'd19, 6'd9
  };

  localparam logic [5:0] PERM_SHA512 [63] = '{
    6'd42, 6'd21, 6'd0, 6'd1, 6'd43, 6'd22, 6'd23, 6'd2, 6'd44,
    6'd45, 6'd24, 6'd3, 6'd4, 6'd46, 6'd25, 6'd26, 6'd5, 6'd47,
    6'd48, 6'd27, 6'd6, 6'd7, 6'd49, 6'd28, 6'd29, 6'd8, 6'd50,
    6'd51, 6'd30, 6'd9, 6'd10, 6'd52, 6'd31, 6'd32, 6'd11, 6'd53,
    6'd54, 6'd33, 6'd12, 6'd13, 6'd55, 6'd34, 6'd35, 6'd14, 6'd56,
    6'd57, 6'd36, 6'd15, 6'd16, 6'd58, 6'd37, 6'd38, 6'd17, 6'd59,
    6'd60, 6'd39, 6'd18, 6'd19, 6'd61, 6'd40, 6'd41, 6'd20, 6'd62
  };

  typedef struct packed {
    logic [1:0]      last_idx;
    logic [2:0][5:0] pos;
    logic [23:0]     acc;
    logic            err;
    logic            done;
  } job_t;

  // Returns {valid, value}.
  function automatic logic [6:0] sixbit(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    t = 8'd0;
    r = 7'd0;
    if (c == CHR_DOT) begin
      r = 7'h40;
    end else if (c == CHR_SLASH) begin
      r = 7'h41;
    end else if (c inside {[8'h30:8'h39]}) begin
      t = c - OFS_DIGIT;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h41:8'h5a]}) begin
      t = c - OFS_UPPER;
      r = {1'b1, t[5:0]};
    end else if (c inside {[8'h61:8'h7a]}) begin
      t = c - OFS_LOWER;
      r = {1'b1, t[5:0]};
    end
    return r;
  endfunction

  function automatic logic [1:0] eff_mode(input logic [1:0] m);
    return (m == MODE_MD5 || m == MODE_SHA256) ? m : MODE_SHA512;
  endfunction

  function automatic logic [6:0] mode_len(input logic [1:0] m);
    logic [6:0] r;
    case (m)
      MODE_MD5:    r = LEN_MD5;
      MODE_SHA256: r = LEN_SHA256;
      default:     r = LEN_SHA512;
    endcase
    return r;
  endfunction

  function automatic logic [4:0] mode_groups(input logic [1:0] m);
    logic [4:0] r;
    case (m)
      MODE_MD5:    r = GROUPS_MD5;
      MODE_SHA256: r = GROUPS_SHA256;
      default:     r = GROUPS_SHA512;
    endcase
    return r;
  endfunction

  function automatic logic [5:0] perm_pos(input logic [1:0] m, input logic [4:0] g,
                                          input logic [1:0] k);
    logic [5:0] idx;
    logic [5:0] r;
    idx = 6'(g * 3) + {4'd0, k};
    r = 6'd0;
    case (m)
      MODE_MD5: begin
        if (idx < 6'd15) r = PERM_MD5[idx[3:0]];
      end
      MODE_SHA256: begin
        if (idx < 6'd30) r = PERM_SHA256[idx[4:0]];
      end
      default: begin
        if (idx < 6'd63) r = PERM_SHA512[idx];
      end
    endcase
    return r;
  endfunction

endpackage

/* sv/cdh_front.sv */
`timescale 1ns / 1ps
// Front end: character decode, group packing and job classification.
module cdh_front import cdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] text_char_i,
  input  logic       end_of_string_i,
  input  logic       mode_we_i,
  input  logic [1:0] mode_i,
  output logic       job_push_o,
  output job_t       job_o
);

  logic [1:0]  mode_q;
  logic [23:0] acc_q, acc_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        disc_q, disc_d;

  logic [1:0]  mode;
  logic [6:0]  len;
  logic [6:0]  cnt_n;
  logic [23:0] acc_n;
  logic [23:0] ext;
  logic [6:0]  sb;
  logic [4:0]  g;

  always_comb begin
    mode       = eff_mode(mode_q);
    len        = mode_len(mode);
    sb         = sixbit(text_char_i);
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    disc_d     = disc_q;
    cnt_n      = cnt_q;
    acc_n      = acc_q;
    job_push_o = 1'b0;
    job_o      = '0;
    case (cnt_q[1:0])
      2'd0:    ext = {18'd0, sb[5:0]};
      2'd1:    ext = {12'd0, sb[5:0], 6'd0};
      2'd2:    ext = {6'd0, sb[5:0], 12'd0};
      default: ext = {sb[5:0], 18'd0};
    endcase
    if (cnt_q < len) begin
      acc_n = acc_q | ext;
      cnt_n = cnt_q + 7'd1;
    end else if (cnt_q < COUNT_MAX) begin
      cnt_n = cnt_q + 7'd1;
    end
    g = cnt_n[6:2] - 5'd1;
    if (accept_i) begin
      if (disc_q) begin
        if (end_of_string_i) begin
          acc_d  = '0;
          cnt_d  = '0;
          disc_d = 1'b0;
        end
      end else if (!sb[6]) begin
        acc_d         = '0;
        cnt_d         = '0;
        disc_d        = !end_of_string_i;
        job_push_o    = 1'b1;
        job_o.err     = 1'b1;
        job_o.done    = 1'b1;
      end else if (end_of_string_i && cnt_n != len) begin
        acc_d         = '0;
        cnt_d         = '0;
        job_push_o    = 1'b1;
        job_o.err     = 1'b1;
        job_o.done    = 1'b1;
      end else begin
        acc_d = acc_n;
        cnt_d = cnt_n;
        job_o.acc = acc_n;
        if (cnt_n[1:0] == 2'd0 && cnt_n != 7'd0 &&
            cnt_n <= {mode_groups(mode), 2'b00}) begin
          job_push_o     = 1'b1;
          job_o.last_idx = 2'd2;
          job_o.pos[0]   = perm_pos(mode, g, 2'd0);
          job_o.pos[1]   = perm_pos(mode, g, 2'd1);
          job_o.pos[2]   = perm_pos(mode, g, 2'd2);
          acc_d          = '0;
        end else if (cnt_n == len) begin
          job_push_o = 1'b1;
          job_o.done = 1'b1;
          acc_d      = '0;
          case (mode)
            MODE_MD5: begin
              job_o.pos[0] = TAIL_POS_MD5;
            end
            MODE_SHA256: begin
              job_o.last_idx = 2'd1;
              job_o.pos[0]   = TAIL_POS_SHA256A;
              job_o.pos[1]   = TAIL_POS_SHA256B;
            end
            default: begin
              job_o.pos[0] = TAIL_POS_SHA512;
            end
          endcase
        end
        if (end_of_string_i) begin
          acc_d = '0;
          cnt_d = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_MD5;
      acc_q  <= '0;
      cnt_q  <= '0;
      disc_q <= 1'b0;
    end else begin
      if (mode_we_i) mode_q <= mode_i;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      disc_q <= disc_d;
    end
  end

endmodule

/* sv/cdh_job_q.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the result sequencer.
module cdh_job_q import cdh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  input  logic pop_i,
  output job_t job_o,
  output logic empty_o,
  output logic full_o
);

  job_t                   slots_q [JOB_Q_DEPTH];
  logic [JOB_Q_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [JOB_Q_CNT_W-1:0] cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == JOB_Q_CNT_W'(JOB_Q_DEPTH));
  assign job_o   = slots_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slots_q[wr_ptr_q] <= job_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + JOB_Q_PTR_W'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + JOB_Q_PTR_W'(1);
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + JOB_Q_CNT_W'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - JOB_Q_CNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= JOB_Q_CNT_W'(JOB_Q_DEPTH)) else $error("job queue overfilled");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full job queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o) else $error("pop from empty job queue");
  a_push_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> !empty_o) else $error("pushed job lost");
`endif

endmodule

/* sv/cdh_back.sv */
`timescale 1ns / 1ps
// Back end: walks each queued job and presents its digest bytes one word at a time.
module cdh_back import cdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  job_t       job_i,
  input  logic       job_empty_i,
  output logic       job_pop_o,
  input  logic       pop_i,
  output logic [5:0] byte_position_o,
  output logic [7:0] byte_value_o,
  output logic       is_error_o,
  output logic       digest_done_o,
  output logic       last_of_run_o
);

  logic [1:0] sub_q;
  logic       last;
  logic       take;

  assign last      = (sub_q == job_i.last_idx);
  assign take      = pop_i && !job_empty_i;
  assign job_pop_o = take && last;

  always_comb begin
    case (sub_q)
      2'd0: begin
        byte_position_o = job_i.pos[0];
        byte_value_o    = job_i.acc[7:0];
      end
      2'd1: begin
        byte_position_o = job_i.pos[1];
        byte_value_o    = job_i.acc[15:8];
      end
      default: begin
        byte_position_o = job_i.pos[2];
        byte_value_o    = job_i.acc[23:16];
      end
    endcase
  end

  assign is_error_o    = job_i.err;
  assign digest_done_o = job_i.done && last;
  assign last_of_run_o = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q <= '0;
    end else if (take) begin
      sub_q <= last ? 2'd0 : sub_q + 2'd1;
    end
  end

endmodule

/* sv/crypt_hash64_digest_decoder_core.sv */
`timescale 1ns / 1ps
// Top level of the hash64 digest text decoder.
//
// Input channel: one digest character per word on text_char_i, with
// end_of_string_i on the final character; a word is taken when push is high
// and full is low. Result channel: while empty is low the oldest result
// sits on byte_position_o, byte_value_o, is_error_o, digest_done_o and
// last_of_run_o; it is taken when pop is high.
// digest_mode_we_i high writes digest_mode_i; the user must do so only
// while idle, unchecked by the block. A character enters every cycle while
// the four-entry job queue has room. Its results appear in the cycle after
// it is taken and drain one per cycle, so sustained input is one character
// per cycle when results are taken at once; the single result port sets the
// long-run pace at three results per four-character group, one per cycle.
// Reset clears the queue, the group state and the mode (MD5). When the
// receiver stalls, results stay on the ports and the queue fills; full then
// rises and holds the sender until the receiver takes results again.
module crypt_hash64_digest_decoder_core import cdh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] text_char_i,
  input  logic       end_of_string_i,
  output logic       empty,
  input  logic       pop,
  output logic [5:0] byte_position_o,
  output logic [7:0] byte_value_o,
  output logic       is_error_o,
  output logic       digest_done_o,
  output logic       last_of_run_o,
  input  logic       digest_mode_we_i,
  input  logic [1:0] digest_mode_i
);

  logic accept;
  logic job_push;
  logic job_pop;
  job_t job_in;
  job_t job_head;

  assign accept = push && !full;

  cdh_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .text_char_i     (text_char_i),
    .end_of_string_i (end_of_string_i),
    .mode_we_i       (digest_mode_we_i),
    .mode_i          (digest_mode_i),
    .job_push_o      (job_push),
    .job_o           (job_in)
  );

  cdh_job_q u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .job_i   (job_in),
    .pop_i   (job_pop),
    .job_o   (job_head),
    .empty_o (empty),
    .full_o  (full)
  );

  cdh_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_head),
    .job_empty_i     (empty),
    .job_pop_o       (job_pop),
    .pop_i           (pop),
    .byte_position_o (byte_position_o),
    .byte_value_o    (byte_value_o),
    .is_error_o      (is_error_o),
    .digest_done_o   (digest_done_o),
    .last_of_run_o   (last_of_run_o)
  );

endmodule

/* verif/crypt_hash64_digest_decoder_core_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the hash64 digest decoder core.
module crypt_hash64_digest_decoder_core_tb;
  import cdh_pkg::*;

  localparam logic [1:0] MODE_ALIAS3 = 2'd3;
  localparam logic [6:0] SAT_COUNT = 7'd127;
  localparam int SETTLE = 8;
  localparam int HOLD_CYCLES = 40;
  localparam int IDLE_LIMIT = 400;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 45;
  localparam int DIR_N = 20;

  localparam logic [5:0] MD5_ORDER [15] = '{
    6'd12, 6'd6, 6'd0, 6'd13, 6'd7, 6'd1, 6'd14, 6'd8, 6'd2,
    6'd15, 6'd9, 6'd3, 6'd5, 6'd10, 6'd4
  };
  localparam logic [5:0] SHA256_ORDER [30] = '{
    6'd20, 6'd10, 6'd0, 6'd11, 6'd1, 6'd21, 6'd2, 6'd22, 6'd12, 6'd23,
    6'd13, 6'd3, 6'd14, 6'd4, 6'd24, 6'd5, 6'd25, 6'd15, 6'd26, 6'd16,
    6'd6, 6'd17, 6'd7, 6'd27, 6'd8, 6'd28, 6'd18, 6'd29, 6'd19, 6'd9
  };
  localparam logic [5:0] SHA512_ORDER [63] = '{
    6'd42, 6'd21, 6'd0, 6'd1, 6'd43, 6'd22, 6'd23, 6'd2, 6'd44,
    6'd45, 6'd24, 6'd3, 6'd4, 6'd46, 6'd25, 6'd26, 6'd5, 6'd47,
    6'd48, 6'd27, 6'd6, 6'd7, 6'd49, 6'd28, 6'd29, 6'd8, 6'd50,
    6'd51, 6'd30, 6'd9, 6'd10, 6'd52, 6'd31, 6'd32, 6'd11, 6'd53,
    6'd54, 6'd33, 6'd12, 6'd13, 6'd55, 6'd34, 6'd35, 6'd14, 6'd56,
    6'd57, 6'd36, 6'd15, 6'd16, 6'd58, 6'd37, 6'd38, 6'd17, 6'd59,
    6'd60, 6'd39, 6'd18, 6'd19, 6'd61, 6'd40, 6'd41, 6'd20, 6'd62
  };

  localparam logic [1:0] PHASE_MODES [PHASES] = '{
    MODE_SHA256, MODE_SHA512, MODE_MD5, MODE_ALIAS3, MODE_SHA256, MODE_MD5
  };

  typedef struct packed {
    logic [5:0] pos;
    logic [7:0] val;
    logic       err;
    logic       done;
    logic       last;
  } digest_byte_t;

  typedef struct packed {
    logic [7:0] chr;
    logic       eos;
    logic       chk;
    logic [5:0] pos;
    logic [7:0] val;
    logic       err;
  } text_row_t;

  typedef enum int {SHAPE_GOOD, SHAPE_LENGTH, SHAPE_BAD_CHAR, SHAPE_NOISE, SHAPE_LONG} shape_e;

  localparam text_row_t TEXT_ROWS [DIR_N] = '{
    '{"z", 1'b1, 1'b1, 6'd0, 8'h00, 1'b1},
    '{8'h00, 1'b0, 1'b1, 6'd0, 8'h00, 1'b1},
    '{"a", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{8'hff, 1'b1, 1'b0, 6'd0, 8'h00, 1'b0},
    '{8'hff, 1'b1, 1'b1, 6'd0, 8'h00, 1'b1},
    '{"z", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"z", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"z", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"z", 1'b0, 1'b1, 6'd0, 8'hff, 1'b0},
    '{".", 1'b1, 1'b1, 6'd0, 8'h00, 1'b1},
    '{".", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"/", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"0", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"9", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"A", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"Z", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"a", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"z", 1'b0, 1'b0, 6'd0, 8'h00, 1'b0},
    '{"@", 1'b0, 1'b1, 6'd0, 8'h00, 1'b1},
    '{"{", 1'b1, 1'b0, 6'd0, 8'h00, 1'b0}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] text_char = 8'd0;
  logic       end_of_string = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [5:0] byte_position;
  logic [7:0] byte_value;
  logic       is_error;
  logic       digest_done;
  logic       last_of_run;
  logic       mode_we = 1'b0;
  logic [1:0] mode_d = MODE_MD5;

  logic       note_chk = 1'b0;
  logic [5:0] note_pos = 6'd0;
  logic [7:0] note_val = 8'd0;
  logic       note_err = 1'b0;

  logic        in_take = 1'b0;
  logic        out_take = 1'b0;
  logic        gaps_on = 1'b1;
  logic        long_hold = 1'b0;
  int          idle_cycles = 0;
  int          errors = 0;

  logic [1:0]  mode_shadow = MODE_MD5;
  logic [23:0] acc_shadow = 24'd0;
  logic [6:0]  count_shadow = 7'd0;
  logic        dropping = 1'b0;
  digest_byte_t pending_bytes [$];

  crypt_hash64_digest_decoder_core DUT (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push             (push),
    .full             (full),
    .text_char_i      (text_char),
    .end_of_string_i  (end_of_string),
    .empty            (empty),
    .pop              (pop),
    .byte_position_o  (byte_position),
    .byte_value_o     (byte_value),
    .is_error_o       (is_error),
    .digest_done_o    (digest_done),
    .last_of_run_o    (last_of_run),
    .digest_mode_we_i (mode_we),
    .digest_mode_i    (mode_d)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic logic [6:0] hash64_value(input logic [7:0] c);
    logic [7:0] t;
    logic [6:0] r;
    r = 7'd0;
    t = 8'd0;
    if (c == CHR_DOT) begin
      r = 7'h40;
    end else if (c == CHR_SLASH) begin
      r = 7'h41;
    end else if (c >= 8'h30 && c <= 8'h39) begin
      t = c - 8'h30 + 8'd2;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h41 && c <= 8'h5a) begin
      t = c - 8'h41 + 8'd12;
      r = {1'b1, t[5:0]};
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      t = c - 8'h61 + 8'd38;
      r = {1'b1, t[5:0]};
    end
    return r;
  endfunction

  function automatic logic [7:0] value_to_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v == 6'd0) return CHR_DOT;
    if (v == 6'd1) return CHR_SLASH;
    if (v < 6'd12) return 8'h30 + w - 8'd2;
    if (v < 6'd38) return 8'h41 + w - 8'd12;
    return 8'h61 + w - 8'd38;
  endfunction

  function automatic logic [7:0] bad_char();
    logic [7:0] c;
    logic [6:0] d;
    c = 8'd0;
    if ($urandom_range(0, 1) == 1) begin
      case ($urandom_range(0, 7))
        0: c = 8'h2d;
        1: c = 8'h3a;
        2: c = 8'h40;
        3: c = 8'h5b;
        4: c = 8'h60;
        5: c = 8'h7b;
        6: c = 8'h00;
        default: c = 8'hff;
      endcase
    end else begin
      do begin
        c = 8'($urandom_range(0, 255));
        d = hash64_value(c);
      end while (d[6]);
    end
    return c;
  endfunction

  function automatic logic [6:0] digest_len(input logic [1:0] m);
    case (m)
      MODE_MD5:    return 7'd22;
      MODE_SHA256: return 7'd43;
      default:     return 7'd86;
    endcase
  endfunction

  function automatic int group_count(input logic [1:0] m);
    case (m)
      MODE_MD5:    return 5;
      MODE_SHA256: return 10;
      default:     return 21;
    endcase
  endfunction

  function automatic logic [5:0] order_pos(input logic [1:0] m, input int idx);
    case (m)
      MODE_MD5:    return MD5_ORDER[idx];
      MODE_SHA256: return SHA256_ORDER[idx];
      default:     return SHA512_ORDER[idx];
    endcase
  endfunction

  function automatic digest_byte_t make_byte(input logic [5:0] p, input logic [7:0] v,
                                             input logic e, input logic d);
    digest_byte_t b;
    b.pos = p;
    b.val = v;
    b.err = e;
    b.done = d;
    b.last = 1'b0;
    return b;
  endfunction

  task automatic clear_run_state();
    acc_shadow = 24'd0;
    count_shadow = 7'd0;
    dropping = 1'b0;
  endtask

  task automatic predict_digest_bytes(input logic [7:0] c, input logic e, output int n);
    digest_byte_t fresh [$];
    digest_byte_t b;
    logic [6:0] d;
    logic [6:0] len;
    logic [1:0] m;
    int g;
    int k;
    m = (mode_shadow > MODE_SHA512) ? MODE_SHA512 : mode_shadow;
    len = digest_len(m);
    d = hash64_value(c);
    if (dropping) begin
      if (e) clear_run_state();
    end else if (!d[6]) begin
      clear_run_state();
      dropping = !e;
      fresh.push_back(make_byte(6'd0, 8'd0, 1'b1, 1'b1));
    end else begin
      if (count_shadow < len) begin
        acc_shadow = acc_shadow | ({18'd0, d[5:0]} << (6 * count_shadow[1:0]));
        count_shadow = count_shadow + 7'd1;
      end else if (count_shadow < SAT_COUNT) begin
        count_shadow = count_shadow + 7'd1;
      end
      if (e && count_shadow != len) begin
        clear_run_state();
        fresh.push_back(make_byte(6'd0, 8'd0, 1'b1, 1'b1));
      end else begin
        if (count_shadow[1:0] == 2'd0 && count_shadow != 7'd0 &&
            count_shadow <= 4 * group_count(m)) begin
          g = count_shadow / 4 - 1;
          for (k = 0; k < 3; k++) begin
            fresh.push_back(make_byte(order_pos(m, 3 * g + k), acc_shadow[8 * k +: 8],
                                      1'b0, 1'b0));
          end
          acc_shadow = 24'd0;
        end else if (count_shadow == len) begin
          case (m)
            MODE_MD5: fresh.push_back(make_byte(6'd11, acc_shadow[7:0], 1'b0, 1'b1));
            MODE_SHA256: begin
              fresh.push_back(make_byte(6'd30, acc_shadow[7:0], 1'b0, 1'b0));
              fresh.push_back(make_byte(6'd31, acc_shadow[15:8], 1'b0, 1'b1));
            end
            default: fresh.push_back(make_byte(6'd63, acc_shadow[7:0], 1'b0, 1'b1));
          endcase
          acc_shadow = 24'd0;
        end
        if (e) clear_run_state();
      end
    end
    n = fresh.size();
    for (k = 0; k < n; k++) begin
      b = fresh[k];
      b.last = (k == n - 1);
      pending_bytes.push_back(b);
    end
  endtask

  task automatic mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(negedge clk) begin : monitor
    digest_byte_t got;
    digest_byte_t want;
    int n;
    if (rst_n) begin
      in_take = push && !full;
      out_take = pop && !empty;
      if (in_take) begin
        predict_digest_bytes(text_char, end_of_string, n);
        if (note_chk) begin
          if (n == 0) begin
            mismatch($sformatf("char %h gave no word", text_char));
          end else begin
            want = pending_bytes[$];
            if (want.pos != note_pos || want.val != note_val || want.err != note_err)
              mismatch($sformatf("char %h: table pos %0d val %h err %b, predicted %0d %h %b",
                                 text_char, note_pos, note_val, note_err,
                                 want.pos, want.val, want.err));
          end
        end
      end
      if (out_take) begin
        got = {byte_position, byte_value, is_error, digest_done, last_of_run};
        if (pending_bytes.size() == 0) begin
          mismatch($sformatf("unexpected word pos %0d val %h", byte_position, byte_value));
        end else begin
          want = pending_bytes.pop_front();
          if (got !== want)
            mismatch($sformatf("pos %0d/%0d val %h/%h err %b/%b done %b/%b last %b/%b",
                               got.pos, want.pos, got.val, want.val, got.err, want.err,
                               got.done, want.done, got.last, want.last));
        end
      end
      if (in_take || out_take) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("crypt_hash64_digest_decoder_core_tb: done, errors");
    $finish;
  end

  initial begin : receiver
    int k;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        pop <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
        long_hold = 1'b0;
        pop <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        pop <= 1'b1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  task automatic put_word(input logic [7:0] c, input logic e, input logic chk,
                          input logic [5:0] p, input logic [7:0] v, input logic er);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    push <= 1'b1;
    text_char <= c;
    end_of_string <= e;
    note_chk <= chk;
    note_pos <= p;
    note_val <= v;
    note_err <= er;
    do @(posedge clk); while (!in_take);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    wait_drain();
    mode_we <= 1'b1;
    mode_d <= m;
    @(posedge clk);
    mode_we <= 1'b0;
    mode_shadow = m;
  endtask

  task automatic send_digest(input shape_e shape, inout int counted);
    int len;
    int n;
    int bad_at;
    int fill;
    int i;
    logic [7:0] c;
    len = digest_len(mode_shadow > MODE_SHA512 ? MODE_SHA512 : mode_shadow);
    fill = $urandom_range(0, 9);
    bad_at = -1;
    case (shape)
      SHAPE_GOOD:   n = len;
      SHAPE_LENGTH: n = $urandom_range(1, len + 6);
      SHAPE_BAD_CHAR: begin
        n = $urandom_range(1, len);
        bad_at = $urandom_range(0, n - 1);
      end
      SHAPE_NOISE: begin
        n = $urandom_range(1, 6);
        bad_at = -2;
      end
      default: n = 130;
    endcase
    for (i = 0; i < n; i++) begin
      if (bad_at == -2) c = 8'($urandom_range(0, 255));
      else if (i == bad_at) c = bad_char();
      else if (fill == 0) c = value_to_char(6'd0);
      else if (fill == 1) c = value_to_char(6'd63);
      else c = value_to_char(6'($urandom_range(0, 63)));
      put_word(c, i == n - 1, 1'b0, 6'd0, 8'd0, 1'b0);
      if (bad_at < 0 || i <= bad_at) counted++;
    end
  endtask

  initial begin : sender
    text_row_t row;
    shape_e shape;
    int ph;
    int i;
    int counted;
    int pick;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (i = 0; i < DIR_N; i++) begin
      row = TEXT_ROWS[i];
      put_word(row.chr, row.eos, row.chk, row.pos, row.val, row.err);
    end
    for (ph = 0; ph < PHASES; ph++) begin
      set_mode(PHASE_MODES[ph]);
      if (ph == PHASES - 1) gaps_on = 1'b0;
      counted = 0;
      if (ph == 0) begin
        long_hold = 1'b1;
        send_digest(SHAPE_GOOD, counted);
        wait_drain();
      end
      if (PHASE_MODES[ph] == MODE_ALIAS3) send_digest(SHAPE_LONG, counted);
      while (counted < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) shape = SHAPE_GOOD;
        else if (pick < 78) shape = SHAPE_LENGTH;
        else if (pick < 90) shape = SHAPE_BAD_CHAR;
        else shape = SHAPE_NOISE;
        send_digest(shape, counted);
      end
    end
    wait_drain();
    if (errors == 0) begin
      $display("crypt_hash64_digest_decoder_core_tb: done, clean");
    end else begin
      $display("crypt_hash64_digest_decoder_core_tb: done, errors");
    end
    $finish;
  end

endmodule
